// ===== rtl/core/pvt_pkg.sv =====
// Shared constants and types for the polyline vertex table.
// No dependencies.
`default_nettype none
package pvt_pkg;
   localparam int MAX_VERTICES_DEF = 256;
   localparam int COORD_BITS_DEF   = 32;

   typedef enum logic [2:0] {
      ACT_APPEND = 3'd0,
      ACT_DELETE = 3'd1,
      ACT_PICK   = 3'd2,
      ACT_INSERT = 3'd3,
      ACT_WRITE  = 3'd4,
      ACT_UNSEL  = 3'd5,
      ACT_READ   = 3'd6,
      ACT_NONE   = 3'd7
   } action_type;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_FULL   = 3'd1;
   localparam logic [2:0] ST_NODEL  = 3'd2;
   localparam logic [2:0] ST_BADIDX = 3'd3;
   localparam logic [2:0] ST_MISS   = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic        rd_en;
      logic        wr_en;
      logic        wr_from_in;
      logic        sq_en;
      logic        ld_en;
      logic        rr_en;
   } cmd_type;
endpackage
`default_nettype wire

// ===== rtl/core/pvt_datapath.sv =====
// Vertex memories, pick distance arithmetic and read capture.
// Depends on pvt_pkg; driven by pvt_control.
`default_nettype none
module pvt_datapath #(
   parameter int MAX_VERTICES = pvt_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = pvt_pkg::COORD_BITS_DEF,
   parameter int AW           = $clog2(MAX_VERTICES)
) (
   input  wire logic                    clock,
   input  wire pvt_pkg::cmd_type        cmd,
   input  wire logic [AW-1:0]           rd_addr,
   input  wire logic [AW-1:0]           wr_addr,
   input  wire logic signed [31:0]      in_x,
   input  wire logic signed [31:0]      in_y,
   input  wire logic [30:0]             radius,
   output logic                         hit,
   output logic signed [31:0]           out_x,
   output logic signed [31:0]           out_y
);
   import pvt_pkg::*;
   localparam int DW = COORD_BITS + 1;
   localparam int SW = 2 * DW + 1;

   logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] rdx_ff, rdy_ff;
   logic signed [COORD_BITS-1:0] pos_x_ff, pos_y_ff;
   logic signed [COORD_BITS-1:0] px, py, wx_in, wy_in;
   logic [DW-1:0]    ax_in, ay_in;
   logic [2*DW-1:0]  sqx_ff, sqy_ff;
   logic [61:0]      rr_ff;
   logic [SW-1:0]    sum;

   assign px = cmd.ld_en ? COORD_BITS'(in_x) : pos_x_ff;
   assign py = cmd.ld_en ? COORD_BITS'(in_y) : pos_y_ff;
   assign wx_in = cmd.wr_from_in ? px : rdx_ff;
   assign wy_in = cmd.wr_from_in ? py : rdy_ff;

   always_ff @(posedge clock) begin
      if (cmd.ld_en) begin
         pos_x_ff <= px;
         pos_y_ff <= py;
      end
      if (cmd.rd_en) begin
         rdx_ff <= mem_x[rd_addr];
         rdy_ff <= mem_y[rd_addr];
      end
      if (cmd.wr_en) begin
         mem_x[wr_addr] <= wx_in;
         mem_y[wr_addr] <= wy_in;
      end
   end

   always_comb begin
      logic signed [DW-1:0] dx, dy;
      dx = DW'(px) - DW'(rdx_ff);
      dy = DW'(py) - DW'(rdy_ff);
      ax_in = dx[DW-1] ? DW'(-dx) : dx;
      ay_in = dy[DW-1] ? DW'(-dy) : dy;
   end

   always_ff @(posedge clock) begin
      if (cmd.rr_en) rr_ff <= 62'(radius) * 62'(radius);
      if (cmd.sq_en) begin
         sqx_ff <= ax_in * ax_in;
         sqy_ff <= ay_in * ay_in;
      end
   end

   assign sum = SW'(sqx_ff) + SW'(sqy_ff);
   assign hit = (sum <= SW'(rr_ff));
   assign out_x = 32'(rdx_ff);
   assign out_y = 32'(rdy_ff);
endmodule
`default_nettype wire

// ===== rtl/core/pvt_control.sv =====
// Sequencer for the vertex table: count, selection, shifts, pick scan, result.
// Depends on pvt_pkg; commands pvt_datapath.
`default_nettype none
module pvt_control #(
   parameter int MAX_VERTICES = pvt_pkg::MAX_VERTICES_DEF,
   parameter int AW           = $clog2(MAX_VERTICES),
   parameter int CW           = $clog2(MAX_VERTICES + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [2:0]       req_action,
   input  wire logic [7:0]       req_slot,
   output pvt_pkg::cmd_type      cmd,
   output logic [AW-1:0]         rd_addr,
   output logic [AW-1:0]         wr_addr,
   output logic                  shift_wr,
   output logic [AW-1:0]         shift_addr,
   input  wire logic             hit,
   input  wire logic signed [31:0] dp_x,
   input  wire logic signed [31:0] dp_y,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [2:0]            rsp_status,
   output logic [8:0]            rsp_count_now,
   output logic                  rsp_sel_valid,
   output logic [7:0]            rsp_sel_index,
   output logic signed [31:0]    rsp_read_x,
   output logic signed [31:0]    rsp_read_y
);
   import pvt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DEL, S_INS, S_PICK_RD, S_PICK_SQ, S_PICK_CMP, S_READ, S_DONE
   } state_type;

   state_type        state_ff;
   action_type       act_ff;
   logic [CW-1:0]    count_ff;
   logic [AW-1:0]    cur_ff;
   logic             selv_ff;
   logic [CW-1:0]    idx_ff;
   logic [CW-1:0]    slot_ff;
   logic [2:0]       st_ff;
   logic             rsp_valid_ff;
   logic [2:0]       rsp_status_ff;
   logic [8:0]       rsp_count_ff;
   logic             rsp_selv_ff;
   logic [7:0]       rsp_seli_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff;
   logic             take;
   logic [CW-1:0]    slot_w;
   logic             finish;
   // shift write phase driven from a registered flag
   logic             wr_ph_ff;

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign take = req_valid && !req_stall;
   assign slot_w = CW'(req_slot);
   assign shift_wr = wr_ph_ff;
   assign shift_addr = AW'(idx_ff);

   always_comb begin
      cmd = '0;
      rd_addr = AW'(idx_ff);
      wr_addr = AW'(idx_ff);
      case (state_ff)
         S_IDLE: begin
            cmd.rr_en = take;
            cmd.ld_en = take;
            cmd.wr_from_in = 1'b1;
            wr_addr = (action_type'(req_action) == ACT_APPEND) ? AW'(count_ff) : AW'(req_slot);
            rd_addr = AW'(req_slot);
            cmd.rd_en = take && (action_type'(req_action) == ACT_READ);
            if (take && action_type'(req_action) == ACT_APPEND && count_ff < CW'(MAX_VERTICES))
               cmd.wr_en = 1'b1;
            if (take && action_type'(req_action) == ACT_WRITE && slot_w < count_ff)
               cmd.wr_en = 1'b1;
         end
         S_DEL: begin
            // two-phase: odd visit reads idx+1, even writes idx
            rd_addr = AW'(idx_ff + 1'b1);
            cmd.rd_en = 1'b1;
         end
         S_INS: begin
            rd_addr = AW'(idx_ff - 1'b1);
            cmd.rd_en = 1'b1;
            if (idx_ff == slot_ff + 1'b1) begin
               cmd.rd_en = 1'b0;
               cmd.wr_en = 1'b1;
               cmd.wr_from_in = 1'b1;
            end
         end
         S_PICK_RD: begin
            cmd.rd_en = 1'b1;
         end
         S_PICK_SQ: cmd.sq_en = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         cur_ff <= '0;
         selv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wr_ph_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (take) begin
               act_ff <= action_type'(req_action);
               slot_ff <= slot_w;
               st_ff <= ST_OK;
               state_ff <= S_DONE;
               case (action_type'(req_action))
                  ACT_APPEND: if (count_ff >= CW'(MAX_VERTICES)) st_ff <= ST_FULL;
                     else begin
                        cur_ff <= AW'(count_ff);
                        selv_ff <= 1'b1;
                        count_ff <= count_ff + 1'b1;
                     end
                  ACT_DELETE: if (count_ff == '0 || !selv_ff) st_ff <= ST_NODEL;
                     else begin
                        idx_ff <= CW'(cur_ff);
                        wr_ph_ff <= 1'b0;
                        state_ff <= S_DEL;
                     end
                  ACT_PICK: begin
                     st_ff <= ST_MISS;
                     idx_ff <= '0;
                     state_ff <= (count_ff == '0) ? S_DONE : S_PICK_RD;
                  end
                  ACT_INSERT: if (count_ff >= CW'(MAX_VERTICES)) st_ff <= ST_FULL;
                     else if (slot_w >= count_ff) st_ff <= ST_BADIDX;
                     else begin
                        idx_ff <= count_ff;
                        wr_ph_ff <= 1'b0;
                        state_ff <= S_INS;
                     end
                  ACT_WRITE: if (slot_w >= count_ff) st_ff <= ST_BADIDX;
                  ACT_UNSEL: begin
                     selv_ff <= 1'b0;
                     cur_ff <= '0;
                  end
                  ACT_READ: if (slot_w >= count_ff) st_ff <= ST_BADIDX;
                     else state_ff <= S_READ;
                  default: ;
               endcase
            end
            S_DEL: begin
               if (wr_ph_ff) begin
                  wr_ph_ff <= 1'b0;
                  idx_ff <= idx_ff + 1'b1;
               end else if (idx_ff + 1'b1 >= count_ff) begin
                  count_ff <= count_ff - 1'b1;
                  selv_ff <= 1'b0;
                  cur_ff <= '0;
                  state_ff <= S_DONE;
               end else begin
                  wr_ph_ff <= 1'b1;
               end
            end
            S_INS: begin
               if (idx_ff == slot_ff + 1'b1) begin
                  count_ff <= count_ff + 1'b1;
                  state_ff <= S_DONE;
               end else if (wr_ph_ff) begin
                  wr_ph_ff <= 1'b0;
                  idx_ff <= idx_ff - 1'b1;
               end else wr_ph_ff <= 1'b1;
            end
            S_PICK_RD: state_ff <= S_PICK_SQ;
            S_PICK_SQ: state_ff <= S_PICK_CMP;
            S_PICK_CMP: begin
               if (hit) begin
                  cur_ff <= AW'(idx_ff);
                  selv_ff <= 1'b1;
                  st_ff <= ST_OK;
                  state_ff <= S_DONE;
               end else if (idx_ff + 1'b1 >= count_ff) state_ff <= S_DONE;
               else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= S_PICK_RD;
               end
            end
            S_READ: state_ff <= S_DONE;
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign finish = (state_ff == S_DONE);
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_status_ff <= st_ff;
         rsp_count_ff <= 9'(count_ff);
         rsp_selv_ff <= selv_ff;
         rsp_seli_ff <= selv_ff ? 8'(cur_ff) : 8'd0;
         rsp_x_ff <= (act_ff == ACT_READ && st_ff == ST_OK) ? dp_x : 32'sd0;
         rsp_y_ff <= (act_ff == ACT_READ && st_ff == ST_OK) ? dp_y : 32'sd0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count_now = rsp_count_ff;
   assign rsp_sel_valid = rsp_selv_ff;
   assign rsp_sel_index = rsp_seli_ff;
   assign rsp_read_x = rsp_x_ff;
   assign rsp_read_y = rsp_y_ff;
endmodule
`default_nettype wire

// ===== rtl/core/pvt_shift.sv =====
// Merges the shift write phase into the controller command to the datapath.
// Depends on pvt_pkg.
`default_nettype none
module pvt_shift #(
   parameter int AW = 8
) (
   input  wire pvt_pkg::cmd_type cmd_in,
   input  wire logic [AW-1:0]    wr_in,
   input  wire logic             shift_wr,
   input  wire logic [AW-1:0]    shift_addr,
   output pvt_pkg::cmd_type      cmd_out,
   output logic [AW-1:0]         wr_out
);
   import pvt_pkg::*;
   always_comb begin
      cmd_out = cmd_in;
      wr_out = wr_in;
      if (shift_wr) begin
         cmd_out.wr_en = 1'b1;
         cmd_out.wr_from_in = 1'b0;
         cmd_out.rd_en = 1'b0;
         wr_out = shift_addr;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/polyline_vertex_table_with_pick.sv =====
// Polyline vertex table with pick: top level.
// Steps per action: append, overwrite, clear selection and errors go straight
// to the result state; read passes through a read state first. Delete and
// insert move vertices by one memory read and one write per moved vertex.
// Pick tests one vertex at a time (read, square, compare), stopping at the
// first hit or after the last vertex.
// One item is in work at a time: req_stall is high from acceptance until
// its result word has been taken on the rsp channel; the next word can be
// accepted in the cycle after that. A stalled result is held unchanged.
// Synchronous reset empties the table (count zero, no selection); vertex
// memories are not cleared, only entries below the count reach a result.
// Depends on pvt_pkg, pvt_control, pvt_shift and pvt_datapath.
`default_nettype none
module polyline_vertex_table_with_pick #(
   parameter int MAX_VERTICES = pvt_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = pvt_pkg::COORD_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_action,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic [7:0]        req_slot,
   input  wire logic [30:0]       req_pick_radius,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [2:0]             rsp_status,
   output logic [8:0]             rsp_count_now,
   output logic                   rsp_sel_valid,
   output logic [7:0]             rsp_sel_index,
   output logic signed [31:0]     rsp_read_x,
   output logic signed [31:0]     rsp_read_y
);
   import pvt_pkg::*;
   localparam int AW = $clog2(MAX_VERTICES);

   cmd_type          cmd_c, cmd_d;
   logic [AW-1:0]    rd_addr, wr_c, wr_d;
   logic             shift_wr;
   logic [AW-1:0]    shift_addr;
   logic             hit;
   logic signed [31:0] dp_x, dp_y;

   pvt_control #(.MAX_VERTICES(MAX_VERTICES)) u_ctl (
      .clock, .reset, .req_valid, .req_stall, .req_action, .req_slot,
      .cmd(cmd_c), .rd_addr, .wr_addr(wr_c), .shift_wr, .shift_addr,
      .hit, .dp_x, .dp_y,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_count_now,
      .rsp_sel_valid, .rsp_sel_index, .rsp_read_x, .rsp_read_y
   );

   pvt_shift #(.AW(AW)) u_sh (
      .cmd_in(cmd_c), .wr_in(wr_c),
      .shift_wr(shift_wr),
      .shift_addr(shift_addr),
      .cmd_out(cmd_d), .wr_out(wr_d)
   );

   pvt_datapath #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_dp (
      .clock, .cmd(cmd_d), .rd_addr, .wr_addr(wr_d),
      .in_x(req_pos_x), .in_y(req_pos_y), .radius(req_pick_radius),
      .hit, .out_x(dp_x), .out_y(dp_y)
   );

`ifndef SYNTHESIS
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept while result pending");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count_now <= 9'(MAX_VERTICES)))
      else $error("count above table size");
   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sel_valid) |-> (9'(rsp_sel_index) < rsp_count_now))
      else $error("selection outside table");
`endif
endmodule
`default_nettype wire

// ===== verif/tb_polyline_vertex_table_with_pick.sv =====
// Self-checking testbench for polyline_vertex_table_with_pick: directed and random
// actions go in, and each response word is checked against an in-bench vertex table model.
// Depends on pvt_pkg and the RTL of the block.
`default_nettype none
module tb_polyline_vertex_table_with_pick;
   timeunit 1ns;
   timeprecision 1ps;
   import pvt_pkg::*;

   localparam int NVERT     = 256;
   localparam int DOG_LIMIT = 40000;

   typedef struct {
      logic [2:0]         status;
      logic [8:0]         count_now;
      logic               sel_valid;
      logic [7:0]         sel_index;
      logic signed [31:0] read_x;
      logic signed [31:0] read_y;
   } table_word;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_action = ACT_NONE;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic [7:0]         req_slot = '0;
   logic [30:0]        req_pick_radius = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_status;
   logic [8:0]         rsp_count_now;
   logic               rsp_sel_valid;
   logic [7:0]         rsp_sel_index;
   logic signed [31:0] rsp_read_x;
   logic signed [31:0] rsp_read_y;

   logic signed [31:0] tbl_x [NVERT];
   logic signed [31:0] tbl_y [NVERT];
   int                 tbl_count;
   int                 tbl_sel;
   bit                 tbl_sel_ok;
   table_word          pending_words [$];

   int  snd_idle_pct;
   int  rcv_idle_pct;
   bit  hold_go;
   int  hold_left;
   int  mismatches;
   int  quiet_cycles;

   polyline_vertex_table_with_pick i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_slot(req_slot),
      .req_pick_radius(req_pick_radius),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_count_now(rsp_count_now), .rsp_sel_valid(rsp_sel_valid),
      .rsp_sel_index(rsp_sel_index), .rsp_read_x(rsp_read_x), .rsp_read_y(rsp_read_y)
   );

   always #1 clock = ~clock;

   function automatic bit in_radius(int i, logic signed [31:0] px, logic signed [31:0] py,
                                    logic [30:0] rad);
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic [65:0]        ax;
      logic [65:0]        ay;
      logic [65:0]        rr;
      dx = {px[31], px} - {tbl_x[i][31], tbl_x[i]};
      dy = {py[31], py} - {tbl_y[i][31], tbl_y[i]};
      ax = (dx < 0) ? 66'(-dx) : 66'(dx);
      ay = (dy < 0) ? 66'(-dy) : 66'(dy);
      rr = 66'(rad);
      return ax * ax + ay * ay <= rr * rr;
   endfunction

   function automatic table_word table_apply(action_type act, logic signed [31:0] px,
                                             logic signed [31:0] py, int slot,
                                             logic [30:0] rad);
      table_word w;
      w = '{status: ST_OK, count_now: 0, sel_valid: 0, sel_index: 0, read_x: 0, read_y: 0};
      case (act)
         ACT_APPEND: begin
            if (tbl_count >= NVERT) w.status = ST_FULL;
            else begin
               tbl_x[tbl_count] = px;
               tbl_y[tbl_count] = py;
               tbl_sel = tbl_count;
               tbl_sel_ok = 1;
               tbl_count++;
            end
         end
         ACT_DELETE: begin
            if (tbl_count == 0 || !tbl_sel_ok) w.status = ST_NODEL;
            else begin
               for (int i = tbl_sel; i + 1 < tbl_count; i++) begin
                  tbl_x[i] = tbl_x[i + 1];
                  tbl_y[i] = tbl_y[i + 1];
               end
               tbl_count--;
               tbl_sel_ok = 0;
               tbl_sel = 0;
            end
         end
         ACT_PICK: begin
            w.status = ST_MISS;
            for (int i = 0; i < tbl_count; i++) begin
               if (in_radius(i, px, py, rad)) begin
                  tbl_sel = i;
                  tbl_sel_ok = 1;
                  w.status = ST_OK;
                  break;
               end
            end
         end
         ACT_INSERT: begin
            if (tbl_count >= NVERT) w.status = ST_FULL;
            else if (slot >= tbl_count) w.status = ST_BADIDX;
            else begin
               for (int i = tbl_count; i > slot + 1; i--) begin
                  tbl_x[i] = tbl_x[i - 1];
                  tbl_y[i] = tbl_y[i - 1];
               end
               tbl_x[slot + 1] = px;
               tbl_y[slot + 1] = py;
               tbl_count++;
            end
         end
         ACT_WRITE: begin
            if (slot >= tbl_count) w.status = ST_BADIDX;
            else begin
               tbl_x[slot] = px;
               tbl_y[slot] = py;
            end
         end
         ACT_UNSEL: begin
            tbl_sel_ok = 0;
            tbl_sel = 0;
         end
         ACT_READ: begin
            if (slot >= tbl_count) w.status = ST_BADIDX;
            else begin
               w.read_x = tbl_x[slot];
               w.read_y = tbl_y[slot];
            end
         end
         default: ;
      endcase
      w.count_now = 9'(tbl_count);
      w.sel_valid = tbl_sel_ok;
      w.sel_index = tbl_sel_ok ? 8'(tbl_sel) : 8'd0;
      return w;
   endfunction

   task automatic send_word(action_type act, logic signed [31:0] px, logic signed [31:0] py,
                            int slot, logic [30:0] rad);
      if ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_pos_x       <= px;
      req_pos_y       <= py;
      req_slot        <= 8'(slot);
      req_pick_radius <= rad;
      do @(posedge clock); while (req_stall);
      pending_words.push_back(table_apply(act, px, py, slot, rad));
   endtask

   task automatic finish_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'sd0;
         3: return -32'sd1;
         4: return 32'($signed($urandom_range(4000)) - 2000);
         default: return $urandom;
      endcase
   endfunction

   always @(posedge clock) begin
      if (hold_go) begin
         hold_left = 600;
         hold_go = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      table_word w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word at %0t", $realtime);
         end else begin
            w = pending_words.pop_front();
            if (rsp_status !== w.status || rsp_count_now !== w.count_now ||
                rsp_sel_valid !== w.sel_valid || rsp_sel_index !== w.sel_index ||
                rsp_read_x !== w.read_x || rsp_read_y !== w.read_y) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: exp st=%0d cnt=%0d sel=%0d/%0d x=%h y=%h",
                           $realtime, w.status, w.count_now, w.sel_valid, w.sel_index,
                           w.read_x, w.read_y,
                           " got st=%0d cnt=%0d sel=%0d/%0d x=%h y=%h",
                           rsp_status, rsp_count_now, rsp_sel_valid, rsp_sel_index,
                           rsp_read_x, rsp_read_y);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= DOG_LIMIT) begin
         $display("tb_polyline_vertex_table_with_pick: errors");
         $finish;
      end
   end

   task automatic test_directed();
      send_word(ACT_DELETE, 0, 0, 0, 0);
      send_word(ACT_PICK, 0, 0, 0, 31'h7fff_ffff);
      send_word(ACT_READ, 0, 0, 0, 0);
      send_word(ACT_INSERT, 0, 0, 0, 0);
      send_word(ACT_APPEND, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0);
      send_word(ACT_APPEND, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0);
      send_word(ACT_APPEND, 100, 200, 0, 0);
      send_word(ACT_PICK, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 31'h7fff_ffff);
      send_word(ACT_PICK, 103, 204, 0, 4);
      send_word(ACT_PICK, 103, 204, 0, 5);
      send_word(ACT_INSERT, 32'sd5, -32'sd5, 0, 0);
      send_word(ACT_INSERT, 0, 0, 4, 0);
      send_word(ACT_WRITE, -32'sd1, 0, 1, 0);
      send_word(ACT_WRITE, 0, 0, 255, 0);
      send_word(ACT_READ, 0, 0, 1, 0);
      send_word(ACT_READ, 0, 0, 3, 0);
      send_word(ACT_READ, 0, 0, 4, 0);
      send_word(ACT_NONE, 0, 0, 0, 0);
      send_word(ACT_DELETE, 0, 0, 0, 0);
      send_word(ACT_DELETE, 0, 0, 0, 0);
      send_word(ACT_APPEND, 1, 1, 0, 0);
      send_word(ACT_UNSEL, 0, 0, 0, 0);
      send_word(ACT_DELETE, 0, 0, 0, 0);
   endtask

   task automatic test_random(int n);
      int                 k;
      int                 j;
      int                 slot;
      action_type         act;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic [30:0]        rad;
      for (int it = 0; it < n; it++) begin
         k = $urandom_range(99);
         if (k < (tbl_count < 40 ? 30 : 8)) act = ACT_APPEND;
         else if (k < 42) act = ACT_DELETE;
         else if (k < 60) act = ACT_PICK;
         else if (k < 72) act = ACT_INSERT;
         else if (k < 82) act = ACT_WRITE;
         else if (k < 87) act = ACT_UNSEL;
         else if (k < 98) act = ACT_READ;
         else act = ACT_NONE;
         px = rand_coord();
         py = rand_coord();
         slot = (tbl_count > 0 && $urandom_range(4) != 0) ? $urandom_range(tbl_count - 1)
                                                          : $urandom_range(255);
         rad = ($urandom_range(2) == 0) ? 31'($urandom) : 31'($urandom_range(3000));
         if (act == ACT_PICK && tbl_count > 0 && $urandom_range(3) != 0) begin
            j = $urandom_range(tbl_count - 1);
            px = tbl_x[j] + 32'($signed($urandom_range(2000)) - 1000);
            py = tbl_y[j] + 32'($signed($urandom_range(2000)) - 1000);
         end
         send_word(act, px, py, slot, rad);
      end
   endtask

   task automatic test_backpressure();
      hold_go = 1;
      test_random(40);
   endtask

   task automatic test_full_table();
      while (tbl_count < NVERT) send_word(ACT_APPEND, $urandom, $urandom, 0, 0);
      send_word(ACT_APPEND, 1, 2, 0, 0);
      send_word(ACT_INSERT, 1, 2, 3, 0);
      send_word(ACT_WRITE, 32'sh7fff_ffff, 32'sh8000_0000, 255, 0);
      send_word(ACT_READ, 0, 0, 255, 0);
      send_word(ACT_PICK, 32'sh7fff_fff0, 32'sh8000_0010, 0, 31'd23);
      send_word(ACT_DELETE, 0, 0, 0, 0);
      send_word(ACT_READ, 0, 0, 254, 0);
   endtask

   initial begin
      snd_idle_pct = 38;
      rcv_idle_pct = 68;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(560);
      snd_idle_pct = 68;
      rcv_idle_pct = 38;
      test_random(560);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      test_backpressure();
      test_random(500);
      test_full_table();
      finish_sending();
      while (pending_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("tb_polyline_vertex_table_with_pick: clean");
      else $display("tb_polyline_vertex_table_with_pick: errors");
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/pvt_pkg.sv
rtl/core/pvt_datapath.sv
rtl/core/pvt_control.sv
rtl/core/pvt_shift.sv
rtl/core/polyline_vertex_table_with_pick.sv
verif/tb_polyline_vertex_table_with_pick.sv
